// File: rtl/mfd_pkg.sv
// mfd_pkg: constants and shared types for the mavlink frame deframer
// no dependencies; used by every module of the block by scoped name

package mfd_pkg;

   // framing constants
   localparam logic [7:0] MAGIC_V1    = 8'hFE;
   localparam logic [7:0] MAGIC_V2    = 8'hFD;
   localparam logic [3:0] HDR_V1      = 4'd6;
   localparam logic [3:0] HDR_V2      = 4'd10;
   localparam int         CRC_BYTES   = 2;
   localparam int         SIG_BYTES   = 13;
   localparam logic [7:0] FLAG_SIGNED = 8'h01;

   // longest possible frame and the widths that follow from it
   localparam int MAX_FRAME_BYTES = 280;
   localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);

   // header byte positions of the length, the flags and the ids
   localparam logic [LEN_W-1:0] IDX_LEN     = LEN_W'(1);
   localparam logic [LEN_W-1:0] IDX_FLAGS   = LEN_W'(2);
   localparam logic [LEN_W-1:0] V1_IDX_SYS  = LEN_W'(3);
   localparam logic [LEN_W-1:0] V1_IDX_COMP = LEN_W'(4);
   localparam logic [LEN_W-1:0] V1_IDX_MSG  = LEN_W'(5);
   localparam logic [LEN_W-1:0] V2_IDX_SYS  = LEN_W'(5);
   localparam logic [LEN_W-1:0] V2_IDX_COMP = LEN_W'(6);
   localparam logic [LEN_W-1:0] V2_IDX_MSG0 = LEN_W'(7);
   localparam logic [LEN_W-1:0] V2_IDX_MSG1 = LEN_W'(8);
   localparam logic [LEN_W-1:0] V2_IDX_MSG2 = LEN_W'(9);

   // one input item as held in the input register
   typedef struct packed {
      logic [7:0] byte_in;
      logic       flush;
   } req_type;

   // one result item
   typedef struct packed {
      logic [7:0]       byte_out;
      logic             is_frame;
      logic             is_first;
      logic             is_last;
      logic             version_two;
      logic [7:0]       sender_sys;
      logic [7:0]       sender_comp;
      logic [23:0]      message_id;
      logic [LEN_W-1:0] frame_length;
      logic [31:0]      dropped_count;
      logic [31:0]      message_count;
   } result_type;

endpackage

// File: rtl/mfd_in_stage.sv
// mfd_in_stage: input register of the deframer with its valid bit
// depends on mfd_pkg for the item type

module mfd_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfd_pkg::req_type req_item,
   input  logic             advance,
   output logic             item_valid,
   output mfd_pkg::req_type item
);

   logic             valid_ff, valid_in;
   mfd_pkg::req_type item_ff;

   // register frees up when its item moves on
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/mfd_parse.sv
// mfd_parse: frame tracking state and the per-byte update logic
// depends on mfd_pkg for constants and the result type

module mfd_parse (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  mfd_pkg::req_type    item,
   output mfd_pkg::result_type result
);

   localparam int W = mfd_pkg::LEN_W;

   logic         in_frame_ff, in_frame_in;
   logic [W-1:0] byte_index_ff, byte_index_in;
   logic [W-1:0] total_length_ff, total_length_in;
   logic         is_v2_ff, is_v2_in;
   logic [3:0]   header_len_ff, header_len_in;
   logic [7:0]   payload_len_ff, payload_len_in;
   logic [7:0]   sys_id_ff, sys_id_in;
   logic [7:0]   comp_id_ff, comp_id_in;
   logic [23:0]  msg_id_ff, msg_id_in;
   logic [31:0]  drop_counter_ff, drop_counter_in;
   logic [31:0]  frame_counter_ff, frame_counter_in;

   logic [7:0]   b;
   logic         is_magic;
   logic [W-1:0] base_len;
   logic [W-1:0] tot_new;
   logic [W:0]   idx_next;
   logic         frame, first, last;

   assign b        = item.byte_in;
   assign is_magic = (b == mfd_pkg::MAGIC_V1) || (b == mfd_pkg::MAGIC_V2);
   assign idx_next = {1'b0, byte_index_ff} + (W+1)'(1);

   // header plus payload plus checksum, payload taken from this byte
   // when it is the length byte
   always_comb begin
      if (byte_index_ff == mfd_pkg::IDX_LEN) begin
         base_len = W'(header_len_ff) + W'(b) + W'(mfd_pkg::CRC_BYTES);
      end else begin
         base_len = W'(header_len_ff) + W'(payload_len_ff) + W'(mfd_pkg::CRC_BYTES);
      end
   end

   // next state and result
   always_comb begin
      in_frame_in      = in_frame_ff;
      byte_index_in    = byte_index_ff;
      total_length_in  = total_length_ff;
      is_v2_in         = is_v2_ff;
      header_len_in    = header_len_ff;
      payload_len_in   = payload_len_ff;
      sys_id_in        = sys_id_ff;
      comp_id_in       = comp_id_ff;
      msg_id_in        = msg_id_ff;
      drop_counter_in  = drop_counter_ff;
      frame_counter_in = frame_counter_ff;
      tot_new          = total_length_ff;
      frame            = 1'b0;
      first            = 1'b0;
      last             = 1'b0;

      if (item.flush) begin
         // drop any partial frame
         in_frame_in     = 1'b0;
         byte_index_in   = '0;
         total_length_in = '0;
      end else if (!in_frame_ff) begin
         // hunting for a magic byte
         if (is_magic) begin
            in_frame_in     = 1'b1;
            is_v2_in        = (b == mfd_pkg::MAGIC_V2);
            header_len_in   = (b == mfd_pkg::MAGIC_V2) ? mfd_pkg::HDR_V2 : mfd_pkg::HDR_V1;
            byte_index_in   = W'(1);
            total_length_in = '0;
            payload_len_in  = '0;
            sys_id_in       = '0;
            comp_id_in      = '0;
            msg_id_in       = '0;
            tot_new         = '0;
            frame           = 1'b1;
            first           = 1'b1;
         end else begin
            drop_counter_in = drop_counter_ff + 32'd1;
         end
      end else begin
         frame = 1'b1;
         // length known from byte 1 on v1, from the flags byte on v2
         if (byte_index_ff == mfd_pkg::IDX_LEN) begin
            payload_len_in = b;
            if (!is_v2_ff) begin
               tot_new = base_len;
            end
         end else if (byte_index_ff == mfd_pkg::IDX_FLAGS && is_v2_ff) begin
            if ((b & mfd_pkg::FLAG_SIGNED) != 8'd0) begin
               tot_new = base_len + W'(mfd_pkg::SIG_BYTES);
            end else begin
               tot_new = base_len;
            end
         end
         total_length_in = tot_new;

         // capture the ids from the header
         if (is_v2_ff) begin
            if (byte_index_ff == mfd_pkg::V2_IDX_SYS) begin
               sys_id_in = b;
            end else if (byte_index_ff == mfd_pkg::V2_IDX_COMP) begin
               comp_id_in = b;
            end else if (byte_index_ff == mfd_pkg::V2_IDX_MSG0) begin
               msg_id_in = {msg_id_ff[23:8], b};
            end else if (byte_index_ff == mfd_pkg::V2_IDX_MSG1) begin
               msg_id_in = {msg_id_ff[23:16], b, msg_id_ff[7:0]};
            end else if (byte_index_ff == mfd_pkg::V2_IDX_MSG2) begin
               msg_id_in = {b, msg_id_ff[15:0]};
            end
         end else begin
            if (byte_index_ff == mfd_pkg::V1_IDX_SYS) begin
               sys_id_in = b;
            end else if (byte_index_ff == mfd_pkg::V1_IDX_COMP) begin
               comp_id_in = b;
            end else if (byte_index_ff == mfd_pkg::V1_IDX_MSG) begin
               msg_id_in = {16'd0, b};
            end
         end

         // end of frame check
         if (tot_new != '0 && idx_next >= {1'b0, tot_new}) begin
            last             = 1'b1;
            in_frame_in      = 1'b0;
            byte_index_in    = '0;
            total_length_in  = '0;
            frame_counter_in = frame_counter_ff + 32'd1;
         end else begin
            byte_index_in = idx_next[W-1:0];
         end
      end

      result.byte_out      = b;
      result.is_frame      = frame;
      result.is_first      = first;
      result.is_last       = last;
      result.version_two   = frame && is_v2_in;
      result.sender_sys    = last ? sys_id_in : 8'd0;
      result.sender_comp   = last ? comp_id_in : 8'd0;
      result.message_id    = last ? msg_id_in : 24'd0;
      result.frame_length  = frame ? tot_new : '0;
      result.dropped_count = drop_counter_in;
      result.message_count = frame_counter_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff      <= 1'b0;
         byte_index_ff    <= '0;
         total_length_ff  <= '0;
         is_v2_ff         <= 1'b0;
         header_len_ff    <= mfd_pkg::HDR_V1;
         payload_len_ff   <= '0;
         sys_id_ff        <= '0;
         comp_id_ff       <= '0;
         msg_id_ff        <= '0;
         drop_counter_ff  <= '0;
         frame_counter_ff <= '0;
      end else if (step) begin
         in_frame_ff      <= in_frame_in;
         byte_index_ff    <= byte_index_in;
         total_length_ff  <= total_length_in;
         is_v2_ff         <= is_v2_in;
         header_len_ff    <= header_len_in;
         payload_len_ff   <= payload_len_in;
         sys_id_ff        <= sys_id_in;
         comp_id_ff       <= comp_id_in;
         msg_id_ff        <= msg_id_in;
         drop_counter_ff  <= drop_counter_in;
         frame_counter_ff <= frame_counter_in;
      end
   end

endmodule

// File: rtl/mfd_out_stage.sv
// mfd_out_stage: result register of the deframer with its valid bit
// depends on mfd_pkg for the result type

module mfd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  mfd_pkg::result_type result,
   output logic                can_take,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output mfd_pkg::result_type rsp_item
);

   logic                valid_ff, valid_in;
   mfd_pkg::result_type item_ff;

   assign can_take = !valid_ff || rsp_ready;

   // hold until taken, refill in the same cycle
   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_item  = item_ff;

endmodule

// File: rtl/mavlink_frame_deframer.sv
// mavlink_frame_deframer: top level, input register, frame parser, result register
// depends on mfd_pkg, mfd_in_stage, mfd_parse and mfd_out_stage
// an accepted item passes through the input register, then waits in the result register until taken
// throughput: one item per cycle while the receiver keeps taking results, set by the parser state update
// flush items update the parser and give no result
// reset (synchronous, active high) empties both registers and returns to hunting

module mavlink_frame_deframer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte_in,
   input  logic        req_flush,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic        rsp_is_frame,
   output logic        rsp_is_first,
   output logic        rsp_is_last,
   output logic        rsp_version_two,
   output logic [7:0]  rsp_sender_sys,
   output logic [7:0]  rsp_sender_comp,
   output logic [23:0] rsp_message_id,
   output logic [8:0]  rsp_frame_length,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_message_count
);

   mfd_pkg::req_type    req_item, item;
   mfd_pkg::result_type result, rsp_item;
   logic                item_valid, advance, load, can_take;

   assign req_item.byte_in = req_byte_in;
   assign req_item.flush   = req_flush;

   // a flush item needs no room in the result register
   assign advance = item_valid && (item.flush || can_take);
   assign load    = advance && !item.flush;

   mfd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   mfd_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item),
      .result (result)
   );

   mfd_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .result    (result),
      .can_take  (can_take),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   // result fields
   assign rsp_byte_out      = rsp_item.byte_out;
   assign rsp_is_frame      = rsp_item.is_frame;
   assign rsp_is_first      = rsp_item.is_first;
   assign rsp_is_last       = rsp_item.is_last;
   assign rsp_version_two   = rsp_item.version_two;
   assign rsp_sender_sys    = rsp_item.sender_sys;
   assign rsp_sender_comp   = rsp_item.sender_comp;
   assign rsp_message_id    = rsp_item.message_id;
   assign rsp_frame_length  = 9'(rsp_item.frame_length);
   assign rsp_dropped_count = rsp_item.dropped_count;
   assign rsp_message_count = rsp_item.message_count;

endmodule

// File: rtl/mfd_checker.sv
// mfd_checker: port-level assertions for the deframer, bound to the top level
// depends on mfd_pkg for the frame length bound

module mfd_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_byte_out,
   input logic        rsp_is_frame,
   input logic        rsp_is_first,
   input logic        rsp_is_last,
   input logic        rsp_version_two,
   input logic [8:0]  rsp_frame_length,
   input logic [31:0] rsp_dropped_count,
   input logic [31:0] rsp_message_count
);

   logic        seen_ff;
   logic [31:0] drop_prev_ff, msg_prev_ff;
   logic [31:0] drop_step, msg_step;
   logic        rsp_take;

   assign rsp_take  = rsp_valid && rsp_ready;
   assign drop_step = rsp_dropped_count - (seen_ff ? drop_prev_ff : 32'd0);
   assign msg_step  = rsp_message_count - (seen_ff ? msg_prev_ff : 32'd0);

   // counters as of the last delivered item
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff      <= 1'b0;
         drop_prev_ff <= '0;
         msg_prev_ff  <= '0;
      end else if (rsp_take) begin
         seen_ff      <= 1'b1;
         drop_prev_ff <= rsp_dropped_count;
         msg_prev_ff  <= rsp_message_count;
      end
   end

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
         && $stable(rsp_message_count) && $stable(rsp_dropped_count))
      else $error("stalled result changed");

   // drop count moves by one on each dropped byte and not otherwise
   a_drop_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> drop_step == (rsp_is_frame ? 32'd0 : 32'd1))
      else $error("dropped count step wrong");

   // frame count moves by one on each last byte and not otherwise
   a_msg_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take |-> msg_step == (rsp_is_last ? 32'd1 : 32'd0))
      else $error("message count step wrong");

   // a closing byte belongs to a frame of known, bounded length
   a_last_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_last |-> rsp_is_frame && rsp_frame_length != 9'd0
         && 32'(rsp_frame_length) <= 32'(mfd_pkg::MAX_FRAME_BYTES))
      else $error("last byte without valid frame length");

   // dropped bytes carry no first mark, version mark or frame length
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_frame |-> !rsp_is_first && !rsp_version_two
         && rsp_frame_length == 9'd0)
      else $error("dropped byte carries frame marks");

endmodule

bind mavlink_frame_deframer mfd_checker u_mfd_checker (.*);

// File: bench/tb_mavlink_frame_deframer.sv
// tb_mavlink_frame_deframer: self-checking bench for the mavlink v1/v2 frame deframer
// depends on mfd_pkg and mavlink_frame_deframer; a scoreboard class predicts every result
// directed framing cases first, then random frames, noise and flushes under random stalls

module tb_mavlink_frame_deframer;

   localparam int CYCLE_LIMIT  = 1000000;
   localparam int STREAM_BYTES = 1650;
   localparam int HOLD_CYCLES  = 400;

   // parser state mirror and the queue of results still owed by the block
   class deframe_scoreboard;
      bit                     in_frame   = 1'b0;
      bit [mfd_pkg::LEN_W-1:0] pos       = '0;
      bit [mfd_pkg::LEN_W-1:0] total_len = '0;
      bit                     v2         = 1'b0;
      bit [3:0]               hdr_len    = mfd_pkg::HDR_V1;
      bit [7:0]               pay_len    = '0;
      bit [7:0]               sys        = '0;
      bit [7:0]               comp       = '0;
      bit [23:0]              msg        = '0;
      bit [31:0]              drops      = '0;
      bit [31:0]              frames     = '0;
      mfd_pkg::result_type    owed[$];
      int unsigned            errors     = 0;

      // advance the mirror by one accepted item and queue what it should produce
      function void note_item(bit [7:0] b, bit flush);
         mfd_pkg::result_type r;
         int                  sum;
         if (flush) begin
            in_frame  = 1'b0;
            pos       = '0;
            total_len = '0;
            return;
         end
         r          = '0;
         r.byte_out = b;
         if (!in_frame) begin
            if (b == mfd_pkg::MAGIC_V1 || b == mfd_pkg::MAGIC_V2) begin
               in_frame   = 1'b1;
               v2         = (b == mfd_pkg::MAGIC_V2);
               hdr_len    = v2 ? mfd_pkg::HDR_V2 : mfd_pkg::HDR_V1;
               pos        = mfd_pkg::LEN_W'(1);
               total_len  = '0;
               pay_len    = '0;
               sys        = '0;
               comp       = '0;
               msg        = '0;
               r.is_frame = 1'b1;
               r.is_first = 1'b1;
            end else begin
               drops = drops + 32'd1;
            end
         end else begin
            r.is_frame = 1'b1;
            // length is known at byte 1 for v1, at the flags byte for v2
            if (pos == mfd_pkg::IDX_LEN) begin
               pay_len = b;
               if (!v2) begin
                  sum       = int'(hdr_len) + int'(pay_len) + mfd_pkg::CRC_BYTES;
                  total_len = mfd_pkg::LEN_W'(sum);
               end
            end else if (pos == mfd_pkg::IDX_FLAGS && v2) begin
               sum = int'(hdr_len) + int'(pay_len) + mfd_pkg::CRC_BYTES;
               if ((b & mfd_pkg::FLAG_SIGNED) != 8'h00) sum = sum + mfd_pkg::SIG_BYTES;
               total_len = mfd_pkg::LEN_W'(sum);
            end
            // header id capture
            if (v2) begin
               if (pos == mfd_pkg::V2_IDX_SYS) sys = b;
               else if (pos == mfd_pkg::V2_IDX_COMP) comp = b;
               else if (pos == mfd_pkg::V2_IDX_MSG0) msg[7:0] = b;
               else if (pos == mfd_pkg::V2_IDX_MSG1) msg[15:8] = b;
               else if (pos == mfd_pkg::V2_IDX_MSG2) msg[23:16] = b;
            end else begin
               if (pos == mfd_pkg::V1_IDX_SYS) sys = b;
               else if (pos == mfd_pkg::V1_IDX_COMP) comp = b;
               else if (pos == mfd_pkg::V1_IDX_MSG) msg = {16'h0000, b};
            end
            // end of frame
            if (total_len != '0 && (int'(pos) + 1) >= int'(total_len)) begin
               r.is_last = 1'b1;
               in_frame  = 1'b0;
               pos       = '0;
               frames    = frames + 32'd1;
            end else begin
               pos = pos + mfd_pkg::LEN_W'(1);
            end
         end
         r.version_two = r.is_frame && v2;
         if (r.is_last) begin
            r.sender_sys  = sys;
            r.sender_comp = comp;
            r.message_id  = msg;
         end
         r.frame_length  = r.is_frame ? total_len : '0;
         r.dropped_count = drops;
         r.message_count = frames;
         if (r.is_last) total_len = '0;
         owed.insert(owed.size(), r);
      endfunction

      function void compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, name, exp_v, act_v);
         end
      endfunction

      // compare one accepted result with the oldest owed one
      function void check_result(mfd_pkg::result_type act);
         mfd_pkg::result_type exp_r;
         if (owed.size() == 0) begin
            errors++;
            $display("%0t: result with no item pending, expected none actual byte %0h",
                     $time, act.byte_out);
            return;
         end
         exp_r = owed.pop_front();
         compare_field("byte_out", 32'(exp_r.byte_out), 32'(act.byte_out));
         compare_field("is_frame", 32'(exp_r.is_frame), 32'(act.is_frame));
         compare_field("is_first", 32'(exp_r.is_first), 32'(act.is_first));
         compare_field("is_last", 32'(exp_r.is_last), 32'(act.is_last));
         compare_field("version_two", 32'(exp_r.version_two), 32'(act.version_two));
         compare_field("sender_sys", 32'(exp_r.sender_sys), 32'(act.sender_sys));
         compare_field("sender_comp", 32'(exp_r.sender_comp), 32'(act.sender_comp));
         compare_field("message_id", 32'(exp_r.message_id), 32'(act.message_id));
         compare_field("frame_length", 32'(exp_r.frame_length), 32'(act.frame_length));
         compare_field("dropped_count", exp_r.dropped_count, act.dropped_count);
         compare_field("message_count", exp_r.message_count, act.message_count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_byte_in;
   logic        req_flush;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_byte_out;
   logic        rsp_is_frame;
   logic        rsp_is_first;
   logic        rsp_is_last;
   logic        rsp_version_two;
   logic [7:0]  rsp_sender_sys;
   logic [7:0]  rsp_sender_comp;
   logic [23:0] rsp_message_id;
   logic [8:0]  rsp_frame_length;
   logic [31:0] rsp_dropped_count;
   logic [31:0] rsp_message_count;

   deframe_scoreboard book = new;
   int  items_sent   = 0;
   int  cycle_count  = 0;
   bit  burst_mode   = 1'b0;
   bit  hold_request = 1'b0;

   mavlink_frame_deframer u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte_in       (req_byte_in),
      .req_flush         (req_flush),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_byte_out      (rsp_byte_out),
      .rsp_is_frame      (rsp_is_frame),
      .rsp_is_first      (rsp_is_first),
      .rsp_is_last       (rsp_is_last),
      .rsp_version_two   (rsp_version_two),
      .rsp_sender_sys    (rsp_sender_sys),
      .rsp_sender_comp   (rsp_sender_comp),
      .rsp_message_id    (rsp_message_id),
      .rsp_frame_length  (rsp_frame_length),
      .rsp_dropped_count (rsp_dropped_count),
      .rsp_message_count (rsp_message_count)
   );

   // clock
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("mavlink_frame_deframer verification failed");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 12);
      else return $urandom_range(20, 60);
   endfunction

   // both channels observed at the falling edge before the edge that moves an item
   always @(negedge clock) begin
      mfd_pkg::result_type act;
      if (!reset) begin
         if (req_valid && req_ready) book.note_item(req_byte_in, req_flush);
         if (rsp_valid && rsp_ready) begin
            act.byte_out      = rsp_byte_out;
            act.is_frame      = rsp_is_frame;
            act.is_first      = rsp_is_first;
            act.is_last       = rsp_is_last;
            act.version_two   = rsp_version_two;
            act.sender_sys    = rsp_sender_sys;
            act.sender_comp   = rsp_sender_comp;
            act.message_id    = rsp_message_id;
            act.frame_length  = rsp_frame_length;
            act.dropped_count = rsp_dropped_count;
            act.message_count = rsp_message_count;
            book.check_result(act);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int on_len;
      int off_len;
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            on_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 100)
                                                 : $urandom_range(1, 8);
            rsp_ready <= 1'b1;
            repeat (on_len) @(posedge clock);
            off_len = pick_gap();
            if (off_len > 0) begin
               rsp_ready <= 1'b0;
               repeat (off_len) @(posedge clock);
            end
         end
      end
   end

   // offer one item and return at the edge that accepts it
   task automatic send_item(input logic [7:0] b, input logic flush);
      int gap;
      gap = burst_mode ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_byte_in <= b;
      req_flush   <= flush;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      items_sent++;
   endtask

   // one frame with random content; a broken frame is cut short by a flush
   task automatic send_frame(input bit v2, input int plen, input bit signed_frame,
                             input bit broken);
      int         total;
      int         cut;
      logic [7:0] b;
      total = (v2 ? int'(mfd_pkg::HDR_V2) : int'(mfd_pkg::HDR_V1)) + plen
              + mfd_pkg::CRC_BYTES + ((v2 && signed_frame) ? mfd_pkg::SIG_BYTES : 0);
      cut   = broken ? $urandom_range(1, total - 1) : total;
      for (int i = 0; i < cut; i++) begin
         if (i == 0) b = v2 ? mfd_pkg::MAGIC_V2 : mfd_pkg::MAGIC_V1;
         else if (i == 1) b = 8'(plen);
         else if (i == 2 && v2)
            b = (8'($urandom) & ~mfd_pkg::FLAG_SIGNED) | 8'(signed_frame);
         else b = 8'($urandom);
         send_item(b, 1'b0);
      end
      if (broken) send_item(8'($urandom), 1'b1);
   endtask

   // sender stops until every owed result is out
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed.size() != 0) @(posedge clock);
   endtask

   // main sequence
   initial begin
      int frame_no;
      int r;
      int plen;
      int noise_len;
      bit v2;
      bit signed_frame;
      bit broken;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_byte_in = 8'h00;
      req_flush   = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // dropped bytes at the extremes and a flush while hunting
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFC, 1'b0);
      send_item(8'hA5, 1'b1);
      // smallest v1 frame, magic values inside it
      send_item(mfd_pkg::MAGIC_V1, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(mfd_pkg::MAGIC_V2, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(mfd_pkg::MAGIC_V1, 1'b0);
      send_item(8'h12, 1'b0);
      send_item(8'h34, 1'b0);
      // smallest v2 frame, unsigned, all other flag bits set
      send_item(mfd_pkg::MAGIC_V2, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFE, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(mfd_pkg::MAGIC_V1, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'hFF, 1'b0);
      send_item(8'h00, 1'b0);
      send_item(8'hFF, 1'b0);
      // flush inside a frame, then hunting again
      send_item(mfd_pkg::MAGIC_V2, 1'b0);
      send_item(8'h03, 1'b0);
      send_item(8'h5A, 1'b1);
      send_item(8'h80, 1'b0);

      // random frames with noise between them
      frame_no = 0;
      while (items_sent < STREAM_BYTES) begin
         burst_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 3) == 0) begin
            noise_len = $urandom_range(1, 4);
            repeat (noise_len) send_item(8'($urandom), $urandom_range(0, 9) == 0);
         end
         v2           = 1'($urandom_range(0, 1));
         signed_frame = 1'($urandom_range(0, 1));
         broken       = ($urandom_range(0, 9) == 0);
         r            = $urandom_range(0, 99);
         if (r < 1) plen = 255;
         else if (r < 15) plen = $urandom_range(13, 60);
         else plen = $urandom_range(0, 12);
         // longest v2 frame and longest v1 frame
         if (frame_no == 4) begin
            v2 = 1'b1; signed_frame = 1'b1; plen = 255; broken = 1'b0;
         end else if (frame_no == 5) begin
            v2 = 1'b0; plen = 255; broken = 1'b0;
         end
         if (frame_no == 8) begin
            burst_mode   = 1'b1;
            hold_request = 1'b1;
         end
         send_frame(v2, plen, signed_frame, broken);
         if (frame_no == 20) wait_drained();
         frame_no++;
      end

      // drain and settle
      req_valid <= 1'b0;
      @(posedge clock);
      while (book.owed.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (book.errors == 0) begin
         $display("mavlink_frame_deframer verification clean");
      end else begin
         $display("mavlink_frame_deframer verification failed");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/mfd_pkg.sv
rtl/mfd_in_stage.sv
rtl/mfd_parse.sv
rtl/mfd_out_stage.sv
rtl/mavlink_frame_deframer.sv
rtl/mfd_checker.sv
bench/tb_mavlink_frame_deframer.sv
